[hw/rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hw/rtl/rnlt_pkg.sv]
// Shared types and constants of the RTP loss tracker.
`timescale 1ns / 1ps
package rnlt_pkg;

    localparam int DefaultDepth = 64;
    localparam int MaxLossGap   = 15;
    localparam int GapW         = 4;
    localparam int SeqW         = 16;
    localparam int TimeW        = 32;
    localparam int FrameW       = 10;
    localparam int WaitW        = 16;
    localparam int BlpW         = 14;

    localparam logic OP_CHECK   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic CFG_FRAME_INTERVAL = 1'b0;
    localparam logic CFG_RESPONSE_WAIT  = 1'b1;

    localparam logic [1:0] STAGE_NONE   = 2'd0;
    localparam logic [1:0] STAGE_FIRST  = 2'd1;
    localparam logic [1:0] STAGE_SECOND = 2'd2;
    localparam logic [1:0] STAGE_PLI    = 2'd3;

    typedef struct packed {
        logic            op;
        logic [SeqW-1:0] seq_num;
        logic [SeqW-1:0] prev_seq_num;
        logic [TimeW-1:0] now_ms;
    } t_req;

    typedef struct packed {
        logic            nack_valid;
        logic [SeqW-1:0] nack_pid;
        logic [BlpW-1:0] nack_blp;
        logic [GapW-1:0] second_nack_count;
        logic            pli_request;
        logic            table_full;
    } t_res;

    typedef struct packed {
        logic [SeqW-1:0]  seq;
        logic [TimeW-1:0] req_ms;
        logic [1:0]       stage;
    } t_entry;

endpackage

[hw/rtl/rnlt_core.sv]
// Loss table engine: table memory, sweep, insert and result build.
`timescale 1ns / 1ps
module rnlt_core #(
    parameter int Depth = rnlt_pkg::DefaultDepth
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  rnlt_pkg::t_req                i_req,
    input  logic [rnlt_pkg::FrameW-1:0]   i_frame_interval,
    input  logic [rnlt_pkg::WaitW-1:0]    i_response_wait,
    input  logic                          i_res_ready,
    output logic                          o_done,
    output rnlt_pkg::t_res                o_res
);
    localparam int AW = $clog2(Depth);
    localparam int NG = rnlt_pkg::MaxLossGap;
    localparam int GW = rnlt_pkg::GapW;
    localparam int SW = rnlt_pkg::SeqW;
    localparam int TW = rnlt_pkg::TimeW;
    localparam int BlpW_L = rnlt_pkg::BlpW + 1;

    typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_INSERT, S_FINISH} t_state;

    t_state               r_state;
    rnlt_pkg::t_req       r_req;
    logic [SW-1:0]        r_pid;
    logic [GW-1:0]        r_gap;
    logic [AW:0]          r_idx;
    logic                 r_rd_vld;
    logic [AW-1:0]        r_rd_addr;
    logic [Depth-1:0]     r_valid;
    logic [NG-1:0]        r_hit;
    logic [AW-1:0]        r_flist [NG];
    logic [GW-1:0]        r_fcnt;
    logic [GW-1:0]        r_fuse;
    logic [GW-1:0]        r_k;
    logic [GW-1:0]        r_nack;
    logic [GW-1:0]        r_second;
    logic                 r_pli;
    logic                 r_pli_v;
    logic [GW-1:0]        r_pli_off;
    logic                 r_full;
    rnlt_pkg::t_entry     r_mem [Depth];
    rnlt_pkg::t_entry     r_rdata;

    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    rnlt_pkg::t_entry     w_wdata;
    logic                 w_ev;
    logic [SW-1:0]        w_off;
    logic [TW-1:0]        w_age;
    logic                 w_drop, w_hit, w_free, w_nack_inc, w_sec_inc;
    logic                 w_pli_set, w_pli_rec, w_ins, w_miss_full;
    logic [SW-1:0]        w_start_pid, w_start_diff;
    logic [SW-1:0]        w_pli_seq, w_pid_fin;
    logic [BlpW_L-1:0]    w_blp_wide;

    // Table memory: one write port, registered read.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[r_idx[AW-1:0]];
    end

    assign w_start_pid  = i_req.prev_seq_num + SW'(1);
    assign w_start_diff = i_req.seq_num - w_start_pid;

    assign w_ev  = r_valid[r_rd_addr];
    assign w_off = r_rdata.seq - r_pid;
    assign w_age = r_req.now_ms - r_rdata.req_ms;

    always_comb begin
        w_we        = 1'b0;
        w_waddr     = r_rd_addr;
        w_wdata     = r_rdata;
        w_drop      = 1'b0;
        w_hit       = 1'b0;
        w_free      = 1'b0;
        w_nack_inc  = 1'b0;
        w_sec_inc   = 1'b0;
        w_pli_set   = 1'b0;
        w_pli_rec   = 1'b0;
        w_ins       = 1'b0;
        w_miss_full = 1'b0;
        if (r_state == S_SWEEP && r_rd_vld) begin
            if (r_req.op == rnlt_pkg::OP_RELEASE) begin
                w_drop = w_ev && (r_rdata.seq <= r_req.seq_num);
            end else begin
                if (w_ev && r_rdata.seq == r_req.seq_num) begin
                    w_drop = 1'b1;
                end else if (w_ev && w_off < SW'(r_gap)) begin
                    w_hit = 1'b1;
                    if (r_rdata.stage == rnlt_pkg::STAGE_NONE) begin
                        if (w_age >= TW'(i_frame_interval)) begin
                            w_we           = 1'b1;
                            w_wdata.req_ms = r_req.now_ms;
                            w_wdata.stage  = rnlt_pkg::STAGE_FIRST;
                            w_nack_inc     = 1'b1;
                        end
                    end else if (w_age >= TW'(i_response_wait)) begin
                        w_we           = 1'b1;
                        w_wdata.req_ms = r_req.now_ms;
                        unique case (r_rdata.stage)
                            rnlt_pkg::STAGE_FIRST: begin
                                w_wdata.stage = rnlt_pkg::STAGE_SECOND;
                                w_sec_inc     = 1'b1;
                                w_nack_inc    = 1'b1;
                            end
                            rnlt_pkg::STAGE_SECOND: begin
                                w_wdata.stage = rnlt_pkg::STAGE_PLI;
                                w_pli_set     = 1'b1;
                                w_pli_rec     = 1'b1;
                            end
                            default: begin
                                w_pli_rec = 1'b1;
                            end
                        endcase
                    end
                end
                w_free = !w_ev || w_drop;
            end
        end
        if (r_state == S_INSERT && r_k < r_gap && !r_hit[r_k]) begin
            if (r_fuse < r_fcnt) begin
                w_we           = 1'b1;
                w_ins          = 1'b1;
                w_waddr        = r_flist[r_fuse];
                w_wdata.seq    = r_pid + SW'(r_k);
                w_wdata.req_ms = r_req.now_ms;
                w_wdata.stage  = rnlt_pkg::STAGE_NONE;
            end else begin
                w_miss_full = 1'b1;
            end
        end
    end

    // Result: move the PID past the highest PLI sequence met.
    assign w_pli_seq  = r_pid + SW'(r_pli_off);
    assign w_pid_fin  = (r_pli_v && w_pli_seq > r_pid) ? w_pli_seq + SW'(1) : r_pid;
    assign w_blp_wide = (BlpW_L'(1) << (r_nack - GW'(1))) - BlpW_L'(1);

    always_comb begin
        o_res = '0;
        o_res.second_nack_count = r_second;
        o_res.pli_request       = r_pli;
        o_res.table_full        = r_full;
        if (w_pid_fin != r_req.seq_num && r_nack != '0) begin
            o_res.nack_valid = 1'b1;
            o_res.nack_pid   = w_pid_fin;
            o_res.nack_blp   = w_blp_wide[rnlt_pkg::BlpW-1:0];
        end
    end

    assign o_done = (r_state == S_FINISH) && i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_req     <= i_req;
                        r_pid     <= w_start_pid;
                        if (i_req.prev_seq_num == i_req.seq_num) begin
                            r_gap <= '0;
                        end else if (w_start_diff > SW'(NG)) begin
                            r_gap <= GW'(NG);
                        end else begin
                            r_gap <= w_start_diff[GW-1:0];
                        end
                        r_idx     <= '0;
                        r_rd_vld  <= 1'b0;
                        r_hit     <= '0;
                        r_fcnt    <= '0;
                        r_fuse    <= '0;
                        r_k       <= '0;
                        r_nack    <= '0;
                        r_second  <= '0;
                        r_pli     <= 1'b0;
                        r_pli_v   <= 1'b0;
                        r_pli_off <= '0;
                        r_full    <= 1'b0;
                        if (i_req.op == rnlt_pkg::OP_CHECK && i_response_wait == '0) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_SWEEP;
                        end
                    end
                end
                S_SWEEP: begin
                    if (r_idx < (AW+1)'(Depth)) begin
                        r_idx     <= r_idx + (AW+1)'(1);
                        r_rd_vld  <= 1'b1;
                        r_rd_addr <= r_idx[AW-1:0];
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    if (r_rd_vld) begin
                        if (w_drop) begin
                            r_valid[r_rd_addr] <= 1'b0;
                        end
                        if (w_hit) begin
                            r_hit[w_off[GW-1:0]] <= 1'b1;
                        end
                        if (w_nack_inc) begin
                            r_nack <= r_nack + GW'(1);
                        end
                        if (w_sec_inc) begin
                            r_second <= r_second + GW'(1);
                        end
                        if (w_pli_set) begin
                            r_pli <= 1'b1;
                        end
                        if (w_pli_rec && (!r_pli_v || w_off[GW-1:0] > r_pli_off)) begin
                            r_pli_v   <= 1'b1;
                            r_pli_off <= w_off[GW-1:0];
                        end
                        if (w_free && r_fcnt < GW'(NG)) begin
                            r_flist[r_fcnt] <= r_rd_addr;
                            r_fcnt          <= r_fcnt + GW'(1);
                        end
                    end
                    if (r_idx == (AW+1)'(Depth) && !r_rd_vld) begin
                        r_state <= (r_req.op == rnlt_pkg::OP_RELEASE) ? S_FINISH : S_INSERT;
                    end
                end
                S_INSERT: begin
                    if (r_k == r_gap) begin
                        r_state <= S_FINISH;
                    end else begin
                        if (w_ins) begin
                            r_valid[r_flist[r_fuse]] <= 1'b1;
                            r_fuse                   <= r_fuse + GW'(1);
                        end
                        if (w_miss_full) begin
                            r_full <= 1'b1;
                        end
                        r_k <= r_k + GW'(1);
                    end
                end
                S_FINISH: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[hw/rtl/rtp_nack_loss_tracker.sv]
// Top level of the RTP loss tracker with NACK and PLI request generation.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// The block keeps up to LostTableDepth lost RTP sequence numbers and for each
// check beat returns one result beat with a generic NACK (PID plus BLP mask),
// the count of second NACKs and a PLI flag; a release beat drops every entry
// at or below its sequence and returns an all-zero result. One beat is worked
// at a time. A check or release sweeps the whole table through its single
// memory port, one entry per cycle, and a check then adds the untracked
// sequence numbers of its gap (gap at most 15); a check with response_wait_ms
// at 0 skips the table and returns an all-zero result. The finished result
// sits in an output register, so the next input beat is taken while it
// waits. Write configuration only while idle; the table needs no clearing
// pass after reset.
module rtp_nack_loss_tracker #(
    parameter int LostTableDepth = rnlt_pkg::DefaultDepth
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_operation,
    input  logic [rnlt_pkg::SeqW-1:0]     i_seq_num,
    input  logic [rnlt_pkg::SeqW-1:0]     i_prev_seq_num,
    input  logic [rnlt_pkg::TimeW-1:0]    i_now_ms,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_nack_valid,
    output logic [rnlt_pkg::SeqW-1:0]     o_nack_pid,
    output logic [rnlt_pkg::BlpW-1:0]     o_nack_blp,
    output logic [rnlt_pkg::GapW-1:0]     o_second_nack_count,
    output logic                          o_pli_request,
    output logic                          o_table_full,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [rnlt_pkg::WaitW-1:0]    i_cfg_data
);
    logic                              r_busy;
    logic                              r_o_valid;
    rnlt_pkg::t_res                    r_res;
    logic [rnlt_pkg::FrameW-1:0]       r_frame_interval;
    logic [rnlt_pkg::WaitW-1:0]        r_response_wait;

    logic                              w_in_acc;
    logic                              w_res_ready;
    logic                              w_done;
    rnlt_pkg::t_req                    w_req;
    rnlt_pkg::t_res                    w_res;

    // Hold off new beats while one is in the table engine.
    assign o_stall     = r_busy;
    assign w_in_acc    = i_valid && !r_busy;
    assign o_cfg_ready = 1'b1;

    // The output register is free when empty or being drained this cycle.
    assign w_res_ready = !r_o_valid || !i_stall;

    assign w_req.op           = i_operation;
    assign w_req.seq_num      = i_seq_num;
    assign w_req.prev_seq_num = i_prev_seq_num;
    assign w_req.now_ms       = i_now_ms;

    rnlt_core #(
        .Depth(LostTableDepth)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (w_in_acc),
        .i_req           (w_req),
        .i_frame_interval(r_frame_interval),
        .i_response_wait (r_response_wait),
        .i_res_ready     (w_res_ready),
        .o_done          (w_done),
        .o_res           (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy           <= 1'b0;
            r_o_valid        <= 1'b0;
            r_res            <= '0;
            r_frame_interval <= rnlt_pkg::FrameW'(66);
            r_response_wait  <= '0;
        end else begin
            // Track the beat in flight.
            if (w_in_acc) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            // Load a finished result, or drop the one just taken.
            if (w_done) begin
                r_o_valid <= 1'b1;
                r_res     <= w_res;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == rnlt_pkg::CFG_FRAME_INTERVAL) begin
                    r_frame_interval <= i_cfg_data[rnlt_pkg::FrameW-1:0];
                end else begin
                    r_response_wait <= i_cfg_data;
                end
            end
        end
    end

    assign o_valid             = r_o_valid;
    assign o_nack_valid        = r_res.nack_valid;
    assign o_nack_pid          = r_res.nack_pid;
    assign o_nack_blp          = r_res.nack_blp;
    assign o_second_nack_count = r_res.second_nack_count;
    assign o_pli_request       = r_res.pli_request;
    assign o_table_full        = r_res.table_full;

    `ASSERT_NEXT(a_accept_sets_busy, i_clk, i_rst_n, w_in_acc, r_busy)
    `ASSERT_IMPLIES(a_done_only_busy, i_clk, i_rst_n, w_done, r_busy)
    `ASSERT_NEXT(a_done_loads_output, i_clk, i_rst_n, w_done, r_o_valid)
    `ASSERT_IMPLIES(a_blp_needs_nack, i_clk, i_rst_n, o_nack_blp != '0, o_nack_valid)

endmodule

[verif/rtp_nack_loss_tracker_checker.sv]
// Result checker for the RTP loss tracker: loss-table predictor and beat compare.
`timescale 1ns / 1ps
module rtp_nack_loss_tracker_checker #(
    parameter int TableDepth = rnlt_pkg::DefaultDepth
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_stall_in,
    input  logic                          i_operation,
    input  logic [rnlt_pkg::SeqW-1:0]     i_seq_num,
    input  logic [rnlt_pkg::SeqW-1:0]     i_prev_seq_num,
    input  logic [rnlt_pkg::TimeW-1:0]    i_now_ms,
    input  logic                          i_res_valid,
    input  logic                          i_res_stall,
    input  logic                          i_nack_valid,
    input  logic [rnlt_pkg::SeqW-1:0]     i_nack_pid,
    input  logic [rnlt_pkg::BlpW-1:0]     i_nack_blp,
    input  logic [rnlt_pkg::GapW-1:0]     i_second_nack_count,
    input  logic                          i_pli_request,
    input  logic                          i_table_full,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [rnlt_pkg::WaitW-1:0]    i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    localparam int SeqW   = rnlt_pkg::SeqW;
    localparam int TimeW  = rnlt_pkg::TimeW;
    localparam int FrameW = rnlt_pkg::FrameW;
    localparam int WaitW  = rnlt_pkg::WaitW;
    localparam int BlpW   = rnlt_pkg::BlpW;

    logic [FrameW-1:0] frame_ms;
    logic [WaitW-1:0]  wait_ms;
    logic [SeqW-1:0]   loss_seq  [TableDepth];
    logic [TimeW-1:0]  loss_time [TableDepth];
    logic [1:0]        loss_stage[TableDepth];
    logic              loss_used [TableDepth];

    // Expected results in flight, kept in a small ring.
    rnlt_pkg::t_res    exp_ring [16];
    logic [3:0]        exp_wr;
    logic [3:0]        exp_rd;
    int                exp_cnt;

    // Walk one beat through the loss table and return the result it yields.
    function automatic rnlt_pkg::t_res track_losses(rnlt_pkg::t_req r);
        rnlt_pkg::t_res   res;
        logic [SeqW-1:0]  pid;
        logic [SeqW-1:0]  gap;
        logic [SeqW-1:0]  pli_seq;
        logic [SeqW-1:0]  ls;
        logic [SeqW-1:0]  k;
        logic [TimeW-1:0] age;
        int               nack_n;
        int               hit;
        int               free_idx;
        res = '0;
        pli_seq = '0;
        nack_n = 0;
        if (r.op == rnlt_pkg::OP_RELEASE) begin
            for (int i = 0; i < TableDepth; i++)
                if (loss_used[i] && loss_seq[i] <= r.seq_num) loss_used[i] = 1'b0;
        end else if (wait_ms != '0) begin
            for (int i = 0; i < TableDepth; i++)
                if (loss_used[i] && loss_seq[i] == r.seq_num) loss_used[i] = 1'b0;
            pid = r.prev_seq_num + 16'd1;
            if (pid != r.seq_num && r.prev_seq_num != r.seq_num) begin
                if (r.prev_seq_num > r.seq_num && r.prev_seq_num > 16'hfff0
                        && r.seq_num < 16'h000f)
                    gap = 16'hffff - r.prev_seq_num + r.seq_num;
                else
                    gap = r.seq_num - pid;
                if (gap > SeqW'(rnlt_pkg::MaxLossGap)) gap = SeqW'(rnlt_pkg::MaxLossGap);
                for (k = '0; k < gap; k++) begin
                    ls = pid + k;
                    hit = -1;
                    free_idx = -1;
                    for (int i = 0; i < TableDepth; i++) begin
                        if (loss_used[i]) begin
                            if (hit < 0 && loss_seq[i] == ls) hit = i;
                        end else if (free_idx < 0) begin
                            free_idx = i;
                        end
                    end
                    if (hit < 0) begin
                        if (free_idx < 0) begin
                            res.table_full = 1'b1;
                        end else begin
                            loss_used[free_idx]  = 1'b1;
                            loss_seq[free_idx]   = ls;
                            loss_time[free_idx]  = r.now_ms;
                            loss_stage[free_idx] = rnlt_pkg::STAGE_NONE;
                        end
                    end else begin
                        age = r.now_ms - loss_time[hit];
                        if (loss_stage[hit] == rnlt_pkg::STAGE_NONE) begin
                            if (age >= TimeW'(frame_ms)) begin
                                loss_time[hit]  = r.now_ms;
                                loss_stage[hit] = rnlt_pkg::STAGE_FIRST;
                                nack_n++;
                            end
                        end else if (age >= TimeW'(wait_ms)) begin
                            loss_time[hit] = r.now_ms;
                            if (loss_stage[hit] == rnlt_pkg::STAGE_FIRST) begin
                                loss_stage[hit] = rnlt_pkg::STAGE_SECOND;
                                res.second_nack_count++;
                                nack_n++;
                            end else if (loss_stage[hit] == rnlt_pkg::STAGE_SECOND) begin
                                loss_stage[hit] = rnlt_pkg::STAGE_PLI;
                                pli_seq = ls;
                                res.pli_request = 1'b1;
                            end else begin
                                pli_seq = ls;
                            end
                        end
                    end
                end
                if (pli_seq > pid) pid = pli_seq + 16'd1;
                if (pid != r.seq_num && nack_n > 0) begin
                    res.nack_valid = 1'b1;
                    res.nack_pid = pid;
                    res.nack_blp = BlpW'((32'd1 << (nack_n - 1)) - 32'd1);
                end
            end
        end
        return res;
    endfunction

    assign o_pending = exp_cnt;

    always @(posedge i_clk) begin
        rnlt_pkg::t_req req;
        rnlt_pkg::t_res got;
        rnlt_pkg::t_res want;
        if (!i_rst_n) begin
            frame_ms <= FrameW'(66);
            wait_ms  <= '0;
            exp_wr   = '0;
            exp_rd   = '0;
            exp_cnt  = 0;
            o_fail_count <= 0;
            for (int i = 0; i < TableDepth; i++) loss_used[i] = 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == rnlt_pkg::CFG_FRAME_INTERVAL)
                    frame_ms <= i_cfg_data[FrameW-1:0];
                else
                    wait_ms <= i_cfg_data;
            end
            if (i_valid && !i_stall_in) begin
                req = '{i_operation, i_seq_num, i_prev_seq_num, i_now_ms};
                exp_ring[exp_wr] = track_losses(req);
                exp_wr  = exp_wr + 4'd1;
                exp_cnt = exp_cnt + 1;
            end
            if (i_res_valid && !i_res_stall) begin
                got = '{i_nack_valid, i_nack_pid, i_nack_blp, i_second_nack_count,
                        i_pli_request, i_table_full};
                if (exp_cnt == 0) begin
                    if (o_fail_count < 10) $display("unexpected result beat %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want    = exp_ring[exp_rd];
                    exp_rd  = exp_rd + 4'd1;
                    exp_cnt = exp_cnt - 1;
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display("result mismatch: expected %p actual %p", want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

[verif/rtp_nack_loss_tracker_tb.sv]
// Testbench top for the RTP loss tracker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module rtp_nack_loss_tracker_tb;
    localparam int SeqW   = rnlt_pkg::SeqW;
    localparam int TimeW  = rnlt_pkg::TimeW;
    localparam int FrameW = rnlt_pkg::FrameW;
    localparam int WaitW  = rnlt_pkg::WaitW;
    localparam int BlpW   = rnlt_pkg::BlpW;
    localparam int GapW   = rnlt_pkg::GapW;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic              i_operation;
    logic [SeqW-1:0]   i_seq_num;
    logic [SeqW-1:0]   i_prev_seq_num;
    logic [TimeW-1:0]  i_now_ms;
    logic              o_valid;
    logic              i_stall;
    logic              o_nack_valid;
    logic [SeqW-1:0]   o_nack_pid;
    logic [BlpW-1:0]   o_nack_blp;
    logic [GapW-1:0]   o_second_nack_count;
    logic              o_pli_request;
    logic              o_table_full;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic              i_cfg_index;
    logic [WaitW-1:0]  i_cfg_data;
    int                fail_count;
    int                pending;

    // Stimulus-side copies of the settings, used only to pace the clock of now_ms.
    int unsigned       frame_set;
    int unsigned       wait_set;
    logic [TimeW-1:0]  clock_ms;
    logic [SeqW-1:0]   window_base;
    bit                no_idle;

    rtp_nack_loss_tracker u_top (.*);

    rtp_nack_loss_tracker_checker u_checker (
        .i_clk, .i_rst_n, .i_valid,
        .i_stall_in(o_stall),
        .i_operation, .i_seq_num, .i_prev_seq_num, .i_now_ms,
        .i_res_valid(o_valid),
        .i_res_stall(i_stall),
        .i_nack_valid(o_nack_valid), .i_nack_pid(o_nack_pid), .i_nack_blp(o_nack_blp),
        .i_second_nack_count(o_second_nack_count), .i_pli_request(o_pli_request),
        .i_table_full(o_table_full),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    // Receiver stall: about 30% of cycles, none during the quiet stretch.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= !no_idle && ($urandom_range(0, 99) < 30);
        end
    end

    // Present one input beat at the falling edge and hold it until the block takes it.
    // Valid stays high after the beat so the next one can follow without a gap.
    task automatic send_beat(logic op, logic [SeqW-1:0] seq, logic [SeqW-1:0] prev,
                             logic [TimeW-1:0] now);
        if (!no_idle && $urandom_range(0, 99) < 30) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_seq_num      <= seq;
        i_prev_seq_num <= prev;
        i_now_ms       <= now;
        #1;
        while (o_stall) begin
            @(negedge i_clk);
            #1;
        end
        @(negedge i_clk);
    endtask

    // Write one register once every outstanding result has drained.
    task automatic write_reg(logic idx, logic [WaitW-1:0] data);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        #1;
        while (!o_cfg_ready) begin
            @(negedge i_clk);
            #1;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == rnlt_pkg::CFG_FRAME_INTERVAL) frame_set = 32'(data[FrameW-1:0]);
        else wait_set = 32'(data);
    endtask

    // Mostly well-formed arrivals in a sliding window so losses get revisited and escalate;
    // the rest are releases, wrapped windows and plain noise.
    task automatic random_beat();
        int unsigned      pick;
        logic [SeqW-1:0]  prev;
        pick = $urandom_range(0, 99);
        clock_ms = clock_ms + $urandom_range(0, frame_set + 2 * wait_set + 4);
        if ($urandom_range(0, 99) < 4)
            window_base = SeqW'(window_base + $urandom_range(0, 64));
        if ($urandom_range(0, 199) == 0)
            window_base = SeqW'(16'hffd8 + $urandom_range(0, 20));
        if (pick < 72) begin
            prev = SeqW'(window_base + $urandom_range(0, 47));
            send_beat(rnlt_pkg::OP_CHECK, SeqW'(prev + $urandom_range(0, 18)), prev,
                      clock_ms);
        end else if (pick < 82) begin
            send_beat(rnlt_pkg::OP_RELEASE, SeqW'(window_base + $urandom_range(0, 48)),
                      SeqW'($urandom), clock_ms);
        end else if (pick < 90) begin
            send_beat(rnlt_pkg::OP_CHECK, SeqW'($urandom), SeqW'($urandom), $urandom);
        end else if (pick < 95) begin
            prev = SeqW'(16'hfff0 + $urandom_range(0, 15));
            send_beat(rnlt_pkg::OP_CHECK, SeqW'($urandom_range(0, 16)), prev, clock_ms);
        end else begin
            send_beat(rnlt_pkg::OP_RELEASE, SeqW'($urandom), SeqW'($urandom), $urandom);
        end
    endtask

    initial begin
        logic [WaitW-1:0] frame_vals[6];
        logic [WaitW-1:0] wait_vals[6];
        int               wait_cycles;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_operation = rnlt_pkg::OP_CHECK;
        i_seq_num   = '0;
        i_prev_seq_num = '0;
        i_now_ms    = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = rnlt_pkg::CFG_FRAME_INTERVAL;
        i_cfg_data  = '0;
        no_idle     = 1'b0;
        frame_set   = 66;
        wait_set    = 0;
        clock_ms    = '0;
        window_base = 16'd100;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: checks are off, only releases touch the table.
        send_beat(rnlt_pkg::OP_CHECK, 16'd20, 16'd5, 32'd0);
        send_beat(rnlt_pkg::OP_RELEASE, 16'hffff, 16'd0, 32'hffff_ffff);

        // Directed: first NACK at once, escalation, wrap and table pressure.
        write_reg(rnlt_pkg::CFG_FRAME_INTERVAL, 16'hfc00);
        write_reg(rnlt_pkg::CFG_RESPONSE_WAIT, 16'd1);
        send_beat(rnlt_pkg::OP_CHECK, 16'd16, 16'd0, 32'd10);
        send_beat(rnlt_pkg::OP_CHECK, 16'd16, 16'd0, 32'd10);
        send_beat(rnlt_pkg::OP_CHECK, 16'd16, 16'd0, 32'd11);
        send_beat(rnlt_pkg::OP_CHECK, 16'd16, 16'd0, 32'd12);
        send_beat(rnlt_pkg::OP_CHECK, 16'd16, 16'd0, 32'd13);
        send_beat(rnlt_pkg::OP_CHECK, 16'd20, 16'd0, 32'd14);
        send_beat(rnlt_pkg::OP_CHECK, 16'd7, 16'd7, 32'd15);
        send_beat(rnlt_pkg::OP_CHECK, 16'd0, 16'hffff, 32'd16);
        send_beat(rnlt_pkg::OP_CHECK, 16'd5, 16'hfff5, 32'd17);
        send_beat(rnlt_pkg::OP_CHECK, 16'd5, 16'hfff5, 32'd18);
        send_beat(rnlt_pkg::OP_CHECK, 16'd3000, 16'd1000, 32'hffff_ffff);
        for (int g = 0; g < 6; g++)
            send_beat(rnlt_pkg::OP_CHECK, 16'd40000 + 16'(g * 16) + 16'd16,
                      16'd40000 + 16'(g * 16), 32'd20);
        send_beat(rnlt_pkg::OP_RELEASE, 16'd0, 16'hffff, 32'd0);
        send_beat(rnlt_pkg::OP_RELEASE, 16'hffff, 16'hffff, 32'd0);

        // Sweep several settings, the extremes among them.
        frame_vals = '{16'd0, 16'd1, 16'd1000, 16'h03ff, 16'(66), 16'($urandom)};
        wait_vals  = '{16'd3, 16'hffff, 16'd20, 16'd1, 16'd100, 16'($urandom_range(1, 500))};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(rnlt_pkg::CFG_FRAME_INTERVAL, frame_vals[ph]);
            write_reg(rnlt_pkg::CFG_RESPONSE_WAIT, wait_vals[ph]);
            for (int n = 0; n < 190; n++) begin
                no_idle = (ph == 2 && n >= 20 && n < 170);
                random_beat();
            end
            no_idle = 1'b0;
        end
        write_reg(rnlt_pkg::CFG_RESPONSE_WAIT, 16'd0);
        for (int n = 0; n < 10; n++) random_beat();
        i_valid <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 20000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (100) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
